@@ rtl/rbc_pkg.sv @@
package rbc_pkg;

	localparam int STAGES_DEF      = 8;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int COEF_BITS_DEF   = 40;

	localparam int WORDS_PER_SEC = 10;
	localparam int INT_BITS      = 10;
	localparam int DIGIT_BITS    = 16;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [3:0] SLOT_DELTA  = 4'd5;
	localparam logic [3:0] SLOT_ENABLE = 4'd10;
	localparam logic [3:0] SLOT_MODE   = 4'd11;

	localparam logic [2:0] LAST_IDX  = 3'd4;
	localparam logic [2:0] FIRST_MUL = 3'd2;
	localparam logic [2:0] FIRST_SUB = 3'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEC,
		ST_TRD,
		ST_TLD,
		ST_TWAIT,
		ST_YOUT,
		ST_RRDC,
		ST_RRDD,
		ST_RLD,
		ST_RMW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic sub;
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

	// term order: b0*x, b1*in1, b2*in2, a1*y1, a2*y2
	function automatic logic [3:0] term_slot(input logic [2:0] t);
		logic [3:0] s;
		case (t)
			3'd0: s = 4'd2;
			3'd1: s = 4'd3;
			3'd2: s = 4'd4;
			3'd3: s = 4'd0;
			default: s = 4'd1;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/ramped_biquad_cascade.sv @@
// Cascade of second-order IIR sections with per-sample coefficient ramping.
// Input beats arrive on s_tvalid/s_tready with the opcode on s_tuser:
//   process sample, write a section word, or clear all section outputs.
// Write and clear beats give no output beat.
// A sample beat walks the enabled sections in order through one shared
// multiply-accumulate unit that takes 16 bits of its second operand a cycle
// (ND = ceil(max(SAMPLE_BITS, COEF_BITS) / 16) digits, 3 at default widths).
// Per enabled section: five products, an output step, then five coefficient
// ramps (additive, or multiplicative for slots 2 to 4 in multiplicative mode),
// plus one section step. A disabled section is skipped.
// s_tready is low while a sample is processed. The result sits in an
// output register on m_tdata, so a new beat is taken while it waits; a
// stalled receiver only holds the block at the end of the next sample.
// Reset clears enables, modes and section outputs; coefficients must be
// written before use.
module ramped_biquad_cascade #(
	parameter int STAGES      = rbc_pkg::STAGES_DEF,
	parameter int SAMPLE_BITS = rbc_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = rbc_pkg::COEF_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sample_in, prev_in_one, prev_in_two, section, slot, word, pad
	input  logic [143:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// sample_out
	output logic [31:0]  m_tdata
);
	import rbc_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int CW    = COEF_BITS;
	localparam int FRAC  = CW - INT_BITS;
	localparam int BW    = (SB > CW) ? SB : CW;
	localparam int ACW   = CW + BW + 3;
	localparam int SHW   = ACW - FRAC;
	localparam int DEPTH = STAGES * WORDS_PER_SEC;
	localparam int RAW   = $clog2(DEPTH);
	localparam int SECW  = (STAGES > 1) ? $clog2(STAGES) : 1;
	localparam int SCW   = $clog2(STAGES + 1);

	logic [1:0]         opcode;
	logic signed [31:0] sample_in;
	logic signed [31:0] prev_in_one;
	logic signed [31:0] prev_in_two;
	logic [2:0]         section;
	logic [3:0]         slot;
	logic signed [39:0] word;

	assign opcode      = s_tuser;
	assign sample_in   = s_tdata[31:0];
	assign prev_in_one = s_tdata[63:32];
	assign prev_in_two = s_tdata[95:64];
	assign section     = s_tdata[98:96];
	assign slot        = s_tdata[102:99];
	assign word        = s_tdata[142:103];

	state_t state_q, state_d;

	logic [SCW-1:0]       sec_q;
	logic [RAW-1:0]       base_q;
	logic [2:0]           t_q;
	logic [2:0]           k_q;
	logic signed [SB-1:0] x_q, i1_q, i2_q;
	logic signed [SB-1:0] h1_q [STAGES];
	logic signed [SB-1:0] h2_q [STAGES];
	logic [STAGES-1:0]    en_q;
	logic [STAGES-1:0]    mm_q;
	logic signed [CW-1:0] c_q;
	logic [31:0]          out_q;
	logic                 out_vld_q;

	logic                 ram_we;
	logic [RAW-1:0]       ram_waddr, ram_raddr;
	logic [CW-1:0]        ram_wdata, ram_rdata;

	mac_cmd_t              mac_cmd;
	mac_stat_t             mac_stat;
	logic signed [CW-1:0]  mac_a;
	logic signed [BW-1:0]  mac_b;
	logic signed [ACW-1:0] mac_acc;

	logic                 accept;
	logic                 sec_ok;
	logic [SECW-1:0]      wsec;
	logic [SECW-1:0]      sidx;
	logic                 sec_end;
	logic [7:0]           wa_full;
	logic signed [CW-1:0] word_sat;
	logic signed [SB-1:0] y1, y2;
	logic signed [SB-1:0] x_new;
	logic signed [CW-1:0] ramp_add, ramp_mul;
	logic signed [CW:0]   sum_ext;
	logic [SHW-1:0]       sh;
	logic                 mul_ramp;
	logic                 out_free;
	logic signed [SB+31:0] x_wide;

	function automatic logic signed [SB-1:0] sat_in(input logic signed [31:0] v);
		logic signed [SB+31:0] e;
		e = (SB + 32)'(v);
		if (&e[SB+31:SB-1] || ~|e[SB+31:SB-1]) begin
			return e[SB-1:0];
		end
		return {e[SB+31], {(SB - 1){~e[SB+31]}}};
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign sec_ok   = (32'(section) < 32'(STAGES));
	assign wsec     = SECW'(section);
	assign sidx     = sec_q[SECW-1:0];
	assign sec_end  = (sec_q == SCW'(STAGES));
	assign wa_full  = {5'b0, section} * 8'd10 + {4'b0, slot};
	assign y1       = h1_q[sidx];
	assign y2       = h2_q[sidx];
	assign mul_ramp = mm_q[sidx] && (k_q >= FIRST_MUL);
	assign out_free = !out_vld_q || m_tready;

	always_comb begin
		logic signed [CW+39:0] e;
		e = (CW + 40)'(word);
		if (&e[CW+39:CW-1] || ~|e[CW+39:CW-1]) begin
			word_sat = e[CW-1:0];
		end else begin
			word_sat = {e[CW+39], {(CW - 1){~e[CW+39]}}};
		end
	end

	// filter output: floor shift, saturate to sample width
	always_comb begin
		logic [SHW-1:0] s;
		s = mac_acc[ACW-1:FRAC];
		if (&s[SHW-1:SB-1] || ~|s[SHW-1:SB-1]) begin
			x_new = s[SB-1:0];
		end else begin
			x_new = {s[SHW-1], {(SB - 1){~s[SHW-1]}}};
		end
	end

	assign sh = mac_acc[ACW-1:FRAC];
	always_comb begin
		if (&sh[SHW-1:CW-1] || ~|sh[SHW-1:CW-1]) begin
			ramp_mul = sh[CW-1:0];
		end else begin
			ramp_mul = {sh[SHW-1], {(CW - 1){~sh[SHW-1]}}};
		end
	end

	assign sum_ext = {c_q[CW-1], c_q} + {ram_rdata[CW-1], ram_rdata};
	always_comb begin
		if (sum_ext[CW] == sum_ext[CW-1]) begin
			ramp_add = sum_ext[CW-1:0];
		end else begin
			ramp_add = {sum_ext[CW], {(CW - 1){~sum_ext[CW]}}};
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = base_q + RAW'(k_q);
		ram_wdata = ramp_add;
		ram_raddr = base_q;
		mac_cmd   = '0;
		mac_a     = ram_rdata;
		mac_b     = BW'($signed(ram_rdata));
		case (state_q)
			ST_IDLE: begin
				ram_waddr = RAW'(wa_full);
				ram_wdata = word_sat;
				if (accept) begin
					if (opcode == OP_WRITE && sec_ok && slot < SLOT_ENABLE) begin
						ram_we = 1'b1;
					end
					if (opcode == OP_SAMPLE) begin
						state_d = ST_SEC;
					end
				end
			end
			ST_SEC: begin
				if (sec_end) begin
					state_d = ST_DONE;
				end else if (en_q[sidx]) begin
					state_d = ST_TRD;
				end
			end
			ST_TRD: begin
				ram_raddr = base_q + RAW'(term_slot(t_q));
				state_d   = ST_TLD;
			end
			ST_TLD: begin
				mac_cmd.start = 1'b1;
				mac_cmd.clear = (t_q == 3'd0);
				mac_cmd.sub   = (t_q >= FIRST_SUB);
				case (t_q)
					3'd0: mac_b = BW'(x_q);
					3'd1: mac_b = BW'(i1_q);
					3'd2: mac_b = BW'(i2_q);
					3'd3: mac_b = BW'(y1);
					default: mac_b = BW'(y2);
				endcase
				state_d = ST_TWAIT;
			end
			ST_TWAIT: begin
				if (mac_stat.done) begin
					state_d = (t_q == LAST_IDX) ? ST_YOUT : ST_TRD;
				end
			end
			ST_YOUT: begin
				state_d = ST_RRDC;
			end
			ST_RRDC: begin
				ram_raddr = base_q + RAW'(k_q);
				state_d   = ST_RRDD;
			end
			ST_RRDD: begin
				ram_raddr = base_q + RAW'(k_q) + RAW'(SLOT_DELTA);
				state_d   = ST_RLD;
			end
			ST_RLD: begin
				if (mul_ramp) begin
					mac_cmd.start = 1'b1;
					mac_cmd.clear = 1'b1;
					mac_a         = c_q;
					mac_b         = BW'($signed(ram_rdata));
					state_d       = ST_RMW;
				end else begin
					ram_we  = 1'b1;
					state_d = (k_q == LAST_IDX) ? ST_SEC : ST_RRDC;
				end
			end
			ST_RMW: begin
				ram_wdata = ramp_mul;
				if (mac_stat.done) begin
					ram_we  = 1'b1;
					state_d = (k_q == LAST_IDX) ? ST_SEC : ST_RRDC;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= '0;
			mm_q      <= '0;
			out_vld_q <= 1'b0;
			sec_q     <= '0;
			base_q    <= '0;
			t_q       <= '0;
			k_q       <= '0;
			for (int i = 0; i < STAGES; i++) begin
				h1_q[i] <= '0;
				h2_q[i] <= '0;
			end
		end else begin
			if (out_vld_q && m_tready && !(state_q == ST_DONE)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (opcode == OP_WRITE && sec_ok) begin
							if (slot == SLOT_ENABLE) begin
								en_q[wsec] <= word[0];
							end
							if (slot == SLOT_MODE) begin
								mm_q[wsec] <= word[0];
							end
						end
						if (opcode == OP_CLEAR) begin
							for (int i = 0; i < STAGES; i++) begin
								h1_q[i] <= '0;
								h2_q[i] <= '0;
							end
						end
						if (opcode == OP_SAMPLE) begin
							sec_q  <= '0;
							base_q <= '0;
						end
					end
				end
				ST_SEC: begin
					t_q <= '0;
					if (!sec_end && !en_q[sidx]) begin
						sec_q  <= sec_q + SCW'(1);
						base_q <= base_q + RAW'(WORDS_PER_SEC);
					end
				end
				ST_TWAIT: begin
					if (mac_stat.done && t_q != LAST_IDX) begin
						t_q <= t_q + 3'd1;
					end
				end
				ST_YOUT: begin
					h1_q[sidx] <= x_new;
					h2_q[sidx] <= y1;
					k_q        <= '0;
				end
				ST_RLD, ST_RMW: begin
					if (ram_we) begin
						if (k_q == LAST_IDX) begin
							sec_q  <= sec_q + SCW'(1);
							base_q <= base_q + RAW'(WORDS_PER_SEC);
						end else begin
							k_q <= k_q + 3'd1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign x_wide = (SB + 32)'(x_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && opcode == OP_SAMPLE) begin
			x_q  <= sat_in(sample_in);
			i1_q <= sat_in(prev_in_one);
			i2_q <= sat_in(prev_in_two);
		end
		if (state_q == ST_YOUT) begin
			x_q  <= x_new;
			i1_q <= y1;
			i2_q <= y2;
		end
		if (state_q == ST_RRDD) begin
			c_q <= ram_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= x_wide[31:0];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	rbc_ram #(
		.WIDTH(CW),
		.DEPTH(DEPTH)
	) u_coef (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rbc_mac #(
		.COEF_BITS(CW),
		.OPB_BITS (BW)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (mac_cmd),
		.a     (mac_a),
		.b     (mac_b),
		.acc   (mac_acc),
		.stat  (mac_stat)
	);

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_SAMPLE) |=> (state_q == ST_SEC && sec_q == '0))
		else $error("sample did not start at first section");
	a_sec_range: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q <= SCW'(STAGES)) else $error("section counter overrun");
	a_busy_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_IDLE) |-> (state_q == ST_RLD || state_q == ST_RMW))
		else $error("coefficient write outside ramp");
	a_mac_idle_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TWAIT && !mac_stat.done) |-> mac_stat.busy)
		else $error("waiting on idle mac");

endmodule

@@ rtl/rbc_ram.sv @@
module rbc_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 80
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/rbc_mac.sv @@
module rbc_mac #(
	parameter int COEF_BITS = 40,
	parameter int OPB_BITS  = 40
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rbc_pkg::mac_cmd_t                      cmd,
	input  logic signed [COEF_BITS-1:0]            a,
	input  logic signed [OPB_BITS-1:0]             b,
	output logic signed [COEF_BITS+OPB_BITS+2:0]   acc,
	output rbc_pkg::mac_stat_t                     stat
);
	import rbc_pkg::*;

	localparam int ND  = (OPB_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int KW  = $clog2(ND);
	localparam int BPW = ND * DIGIT_BITS;
	localparam int PW  = COEF_BITS + DIGIT_BITS + 1;
	localparam int ACW = COEF_BITS + OPB_BITS + 3;

	logic signed [COEF_BITS-1:0] a_q;
	logic signed [BPW-1:0]       b_q;
	logic [KW-1:0]               k_q;
	logic                        run_q;
	logic                        sub_q;
	logic signed [PW-1:0]        prod_s1;
	logic [KW-1:0]               kpos_s1;
	logic                        vld_s1;
	logic                        last_s1;
	logic signed [ACW-1:0]       acc_q;
	logic                        done_q;

	logic signed [DIGIT_BITS:0]  dig;
	logic                        last_dig;
	logic signed [ACW-1:0]       term;

	assign last_dig = (k_q == KW'(ND - 1));
	assign dig = {last_dig ? b_q[BPW-1] : 1'b0, b_q[k_q*DIGIT_BITS +: DIGIT_BITS]};
	assign term = ACW'(prod_s1) <<< (DIGIT_BITS * kpos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= vld_s1 && last_s1;
			vld_s1 <= run_q;
			if (cmd.start) begin
				run_q <= 1'b1;
				k_q   <= '0;
			end else if (run_q) begin
				k_q <= k_q + KW'(1);
				if (last_dig) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q   <= a;
			b_q   <= BPW'(b);
			sub_q <= cmd.sub;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end
		if (run_q) begin
			prod_s1 <= PW'(a_q * dig);
			kpos_s1 <= k_q;
			last_s1 <= last_dig;
		end
		if (vld_s1) begin
			acc_q <= sub_q ? acc_q - term : acc_q + term;
		end
	end

	assign acc       = acc_q;
	assign stat.busy = run_q | vld_s1;
	assign stat.done = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !(run_q || vld_s1)) else $error("mac restarted while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && last_s1) |=> done_q) else $error("mac done missing");
	a_run_drains: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(run_q) |-> vld_s1 && last_s1) else $error("mac stopped early");

endmodule
